@@ rtl/core/pmst_pkg.sv @@
// ----------------------------------------------------------------------------
// pmst_pkg: shared types and constants of the dense-matrix spanning tree block
// Command and result payloads, operation codes, sequencer states and the
// control group passed to the vertex state unit.
// ----------------------------------------------------------------------------
package pmst_pkg;

	localparam int ROW_W    = 6;
	localparam int COL_W    = 6;
	localparam int WEIGHT_W = 16;
	localparam int COST_W   = 22;
	localparam int VCOUNT_W = 7;

	localparam int COST_MAX = 2097151;
	localparam int COST_MIN = -2097152;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	typedef struct packed {
		logic                       op;
		logic [ROW_W-1:0]           row;
		logic [COL_W-1:0]           col;
		logic signed [WEIGHT_W-1:0] weight;
	} cmd_t;

	typedef struct packed {
		logic signed [COST_W-1:0] total_cost;
		logic                     connected;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_RELAX,
		S_DRAIN,
		S_NEXT,
		S_SUM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic relax;
		logic restart;
	} vu_ctl_t;

endpackage

@@ rtl/core/prim_mst_dense_matrix.sv @@
// ----------------------------------------------------------------------------
// prim_mst_dense_matrix: minimum spanning tree weight over a dense matrix
// Stores a signed weight matrix and runs Prim's algorithm from vertex 0.
// ----------------------------------------------------------------------------
// Usage. A command is taken when start is high and busy is low. A write
// command stores one matrix entry and leaves busy low; entries
// whose row or column lies beyond the matrix are dropped. A compute command
// raises busy, then returns one result on the cycle that done is high.
// Zero entries mean no edge. Every entry in use must be written first.
// Compute sequence with n active vertices: a sweep clears the vertex
// memory, then up to n rounds follow (one vertex read, relaxed and written
// back per cycle through the vertex memory port), and a closing sum reads
// the matrix once for each vertex other than vertex 0. When the graph is
// disconnected the rounds stop early and connected is 0.
// The cost saturates to the signed result range.
// The vertex count is written on the cfg channel, which is always ready; it
// must only change while busy is low. Reset sets the count to 64 and
// returns to idle; matrix contents are not cleared. The receiver cannot
// stall: each result is valid for the single cycle that done is high.
// ----------------------------------------------------------------------------
module prim_mst_dense_matrix #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  pmst_pkg::cmd_t                  cmd,
	output logic                            done,
	output pmst_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pmst_pkg::VCOUNT_W-1:0]   cfg_data
);
	import pmst_pkg::*;

	localparam int IDX_W     = $clog2(MAX_VERTICES);
	localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
	localparam int NW        = (CNT_W > VCOUNT_W) ? CNT_W : VCOUNT_W;
	localparam int EXT_W     = (CNT_W > ROW_W) ? CNT_W : ROW_W;
	localparam int MAT_DEPTH = 1 << (2 * IDX_W);
	localparam int ACC_W     = WEIGHT_BITS + IDX_W + 1;
	localparam int SAT_W     = (ACC_W > COST_W) ? ACC_W : COST_W;
	localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(COST_MAX);
	localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(COST_MIN);

	state_t                        state_q, state_d;
	logic [VCOUNT_W-1:0]           vcount_q;
	logic [CNT_W-1:0]              n_q, n_d;
	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              round_q;
	logic [IDX_W-1:0]              x_q;
	logic                          connected_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          sum_s1, sum_s2;
	logic [IDX_W-1:0]              sidx_s1;

	logic signed [WEIGHT_BITS-1:0] mat_mem [MAT_DEPTH];
	logic signed [WEIGHT_BITS-1:0] mat_q;
	logic [IDX_W-1:0]              rd_row, rd_col;
	logic                          mat_we;
	logic [EXT_W-1:0]              row_ext, col_ext;

	vu_ctl_t                       vctl;
	logic                          best_found;
	logic [IDX_W-1:0]              best_idx;
	logic                          rd_in_tree;
	logic [IDX_W-1:0]              rd_parent;

	logic                          take;
	logic                          last_cnt;
	logic                          last_round;
	logic                          sum_iss;
	logic [NW-1:0]                 vc_ext;
	logic signed [SAT_W-1:0]       acc_ext;

	assign take      = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Active vertex count: zero acts as one, large values clamp to the matrix.
	always_comb begin
		vc_ext = NW'(vcount_q);
		if (vc_ext == '0) begin
			n_d = CNT_W'(1);
		end else if (vc_ext > NW'(MAX_VERTICES)) begin
			n_d = CNT_W'(MAX_VERTICES);
		end else begin
			n_d = CNT_W'(vc_ext);
		end
	end

	assign last_cnt   = (cnt_q == n_q - CNT_W'(1));
	assign last_round = (round_q + CNT_W'(1) == n_q);
	assign sum_iss    = (state_q == S_SUM) && (cnt_q < n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= cfg_data;
		end
	end

	// Weight matrix: written by write commands, read by relax and sum sweeps.
	assign row_ext = EXT_W'(cmd.row);
	assign col_ext = EXT_W'(cmd.col);
	assign mat_we  = take && cmd.op == OP_WRITE &&
		row_ext < EXT_W'(MAX_VERTICES) && col_ext < EXT_W'(MAX_VERTICES);

	assign rd_row = (state_q == S_RELAX) ? x_q : sidx_s1;
	assign rd_col = (state_q == S_RELAX) ? cnt_q[IDX_W-1:0] : rd_parent;

	always_ff @(posedge clk) begin
		mat_q <= mat_mem[{rd_row, rd_col}];
		if (mat_we) begin
			mat_mem[{row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]}] <= WEIGHT_BITS'($unsigned(cmd.weight));
		end
	end

	assign vctl.clear   = (state_q == S_CLEAR);
	assign vctl.relax   = (state_q == S_RELAX);
	assign vctl.restart = (state_q == S_CLEAR) || (state_q == S_NEXT);

	pmst_vertex_unit #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_vertex (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (vctl),
		.addr       (cnt_q[IDX_W-1:0]),
		.sel        (x_q),
		.edge_w     (mat_q),
		.best_found (best_found),
		.best_idx   (best_idx),
		.rd_in_tree (rd_in_tree),
		.rd_parent  (rd_parent)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take && cmd.op == OP_COMPUTE) state_d = S_CLEAR;
			end
			S_CLEAR: begin
				if (last_cnt) state_d = S_RELAX;
			end
			S_RELAX: begin
				if (last_cnt) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_NEXT;
			end
			S_NEXT: begin
				if (last_round || !best_found) begin
					state_d = S_SUM;
				end else begin
					state_d = S_RELAX;
				end
			end
			S_SUM: begin
				if (!sum_iss && !sum_s1 && !sum_s2) state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_s1  <= 1'b0;
			sum_s2  <= 1'b0;
		end else begin
			state_q <= state_d;
			sum_s1  <= sum_iss;
			sum_s2  <= sum_s1 && rd_in_tree;
		end
	end

	always_ff @(posedge clk) begin
		sidx_s1 <= cnt_q[IDX_W-1:0];
		if (sum_s2) begin
			acc_q <= acc_q + ACC_W'(mat_q);
		end
		case (state_q)
			S_IDLE: begin
				n_q   <= n_d;
				cnt_q <= '0;
			end
			S_CLEAR: begin
				if (last_cnt) begin
					cnt_q       <= '0;
					x_q         <= '0;
					round_q     <= '0;
					connected_q <= 1'b1;
					acc_q       <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			S_RELAX: begin
				if (!last_cnt) cnt_q <= cnt_q + CNT_W'(1);
			end
			S_NEXT: begin
				if (last_round) begin
					cnt_q <= CNT_W'(1);
				end else if (!best_found) begin
					connected_q <= 1'b0;
					cnt_q       <= CNT_W'(1);
				end else begin
					x_q     <= best_idx;
					round_q <= round_q + CNT_W'(1);
					cnt_q   <= '0;
				end
			end
			S_SUM: begin
				if (sum_iss) cnt_q <= cnt_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign acc_ext = SAT_W'(acc_q);

	always_comb begin
		if (acc_ext > SAT_HI) begin
			result.total_cost = SAT_HI[COST_W-1:0];
		end else if (acc_ext < SAT_LO) begin
			result.total_cost = SAT_LO[COST_W-1:0];
		end else begin
			result.total_cost = acc_ext[COST_W-1:0];
		end
		result.connected = connected_q;
	end

	assign done = (state_q == S_DONE);

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.op == OP_COMPUTE) |=> busy)
		else $error("compute transfer did not raise busy");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.op == OP_WRITE) |=> !busy)
		else $error("matrix write transfer left the block busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block stayed busy after delivering a result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && state_q != S_DONE) |-> (n_q != '0 && n_q <= CNT_W'(MAX_VERTICES)))
		else $error("active vertex count out of range during compute");

	a_sum_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		sum_s2 |-> state_q == S_SUM)
		else $error("sum pipeline active outside the sum sweep");

endmodule

@@ rtl/core/pmst_vertex_unit.sv @@
// ----------------------------------------------------------------------------
// pmst_vertex_unit: per-vertex state memory with relaxation and minimum search
// Holds tree membership, distance and parent of each vertex in one memory.
// A relax sweep reads each vertex, updates it against the selected row and
// writes it back in the following cycle while tracking the next vertex to select.
// ----------------------------------------------------------------------------
module pmst_vertex_unit #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pmst_pkg::vu_ctl_t                 ctl,
	input  logic [$clog2(MAX_VERTICES)-1:0]   addr,
	input  logic [$clog2(MAX_VERTICES)-1:0]   sel,
	input  logic signed [WEIGHT_BITS-1:0]     edge_w,
	output logic                              best_found,
	output logic [$clog2(MAX_VERTICES)-1:0]   best_idx,
	output logic                              rd_in_tree,
	output logic [$clog2(MAX_VERTICES)-1:0]   rd_parent
);
	import pmst_pkg::*;

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int DEPTH = 1 << IDX_W;
	localparam int VS_W  = 2 + WEIGHT_BITS + IDX_W;

	logic [VS_W-1:0]               vmem [DEPTH];
	logic [VS_W-1:0]               rdata_q;
	logic                          rlx_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic                          best_found_q;
	logic [IDX_W-1:0]              best_idx_q;
	logic signed [WEIGHT_BITS-1:0] best_dist_q;

	logic                          old_in, old_valid;
	logic signed [WEIGHT_BITS-1:0] old_dist;
	logic                          new_in, new_valid;
	logic signed [WEIGHT_BITS-1:0] new_dist;
	logic [IDX_W-1:0]              new_par;
	logic                          cand;
	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	logic [VS_W-1:0]               wr_data;

	assign old_in    = rdata_q[VS_W-1];
	assign old_valid = rdata_q[VS_W-2];
	assign old_dist  = rdata_q[IDX_W+WEIGHT_BITS-1:IDX_W];

	assign rd_in_tree = old_in;
	assign rd_parent  = rdata_q[IDX_W-1:0];

	always_comb begin
		new_in    = old_in;
		new_valid = old_valid;
		new_dist  = old_dist;
		new_par   = rdata_q[IDX_W-1:0];
		if (idx_s1 == sel) begin
			new_in = 1'b1;
		end else if (!old_in && edge_w != '0 && (!old_valid || edge_w < old_dist)) begin
			new_valid = 1'b1;
			new_dist  = edge_w;
			new_par   = sel;
		end
		// Strict compare keeps the lowest index on a tie, since indexes ascend.
		cand = !new_in && new_valid && (!best_found_q || new_dist < best_dist_q);
	end

	always_comb begin
		wr_en = ctl.clear || rlx_s1;
		if (ctl.clear) begin
			wr_addr = addr;
			wr_data = {1'b0, (addr == '0), {WEIGHT_BITS{1'b0}}, {IDX_W{1'b0}}};
		end else begin
			wr_addr = idx_s1;
			wr_data = {new_in, new_valid, new_dist, new_par};
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= vmem[addr];
		if (wr_en) begin
			vmem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rlx_s1       <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			rlx_s1 <= ctl.relax;
			if (ctl.restart) begin
				best_found_q <= 1'b0;
			end else if (rlx_s1 && cand) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr;
		if (rlx_s1 && cand && !ctl.restart) begin
			best_idx_q  <= idx_s1;
			best_dist_q <= new_dist;
		end
	end

	assign best_found = best_found_q;
	assign best_idx   = best_idx_q;

endmodule
